### hdl/llpa_pkg.sv
package llpa_pkg;

	localparam int TYPE_W      = 3;
	localparam int LAYER_W     = 3;
	localparam int PORT_CUE_W  = 8;
	localparam int INTENSITY_W = 16;
	localparam int TIME_W      = 48;
	localparam int CMD_W       = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int LAYER_ID_W  = 5;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// fixed layer slots, higher number wins
	localparam logic [LAYER_ID_W-1:0] LAYER_TOUCH      = 5'd3;
	localparam logic [LAYER_ID_W-1:0] LAYER_FOREGROUND = 5'd4;
	localparam logic [LAYER_ID_W-1:0] LAYER_GROWTH     = 5'd5;

	typedef enum logic [TYPE_W-1:0] {
		REQ_TICK  = 3'd0,
		REQ_FILL  = 3'd1,
		REQ_CLEAR = 3'd2,
		REQ_PLAY  = 3'd3,
		REQ_STOP  = 3'd4
	} req_type_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACK  = 3'd0,
		CMD_STOP = 3'd1,
		CMD_SET  = 3'd2,
		CMD_PLAY = 3'd3,
		CMD_TICK = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_INTENSITY = 2'd0,
		CFG_FG_INTENSITY  = 2'd1,
		CFG_ERROR_CUE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [INTENSITY_W-1:0] max_intensity;
		logic [INTENSITY_W-1:0] fg_intensity;
		logic [PORT_CUE_W-1:0]  error_cue;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]       command;
		logic [PORT_CUE_W-1:0]  cmd_cue;
		logic [INTENSITY_W-1:0] cmd_intensity;
		logic [TIME_W-1:0]      cmd_time;
		logic                   status;
		logic                   last;
		logic                   emitting;
		logic [PORT_CUE_W-1:0]  shown_cue;
		logic                   interferes;
	} result_t;

endpackage

### hdl/llpa_if.sv
interface llpa_req_if import llpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [TYPE_W-1:0]      req_type;
	logic [LAYER_W-1:0]     layer;
	logic [PORT_CUE_W-1:0]  cue;
	logic [INTENSITY_W-1:0] intensity;
	logic [TIME_W-1:0]      now_time;
	logic [TIME_W-1:0]      duration;

	modport source (output valid, req_type, layer, cue, intensity, now_time, duration,
		input ready);
	modport sink (input valid, req_type, layer, cue, intensity, now_time, duration,
		output ready);
endinterface

interface llpa_res_if import llpa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [PORT_CUE_W-1:0]  cmd_cue;
	logic [INTENSITY_W-1:0] cmd_intensity;
	logic [TIME_W-1:0]      cmd_time;
	logic                   status;
	logic                   last;
	logic                   emitting;
	logic [PORT_CUE_W-1:0]  shown_cue;
	logic                   interferes;

	modport source (output valid, command, cmd_cue, cmd_intensity, cmd_time, status, last,
		emitting, shown_cue, interferes, input ready);
	modport sink (input valid, command, cmd_cue, cmd_intensity, cmd_time, status, last,
		emitting, shown_cue, interferes, output ready);
endinterface

interface llpa_cfg_if import llpa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/llpa_slot_mem.sv
module llpa_slot_mem #(
	parameter int DEPTH = 7,
	parameter int WIDTH = 72,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/llpa_ctrl.sv
module llpa_ctrl import llpa_pkg::*; #(
	parameter int NUM_LAYERS = 7,
	parameter int CUE_WIDTH = 8,
	localparam int LW = $clog2(NUM_LAYERS),
	localparam int SW = CUE_WIDTH + INTENSITY_W + TIME_W
) (
	input  logic          clk,
	input  logic          arst_n,
	llpa_req_if.sink      req,
	input  cfg_t          cfg,
	output logic          mem_we,
	output logic [LW-1:0] mem_waddr,
	output logic [SW-1:0] mem_wdata,
	output logic [LW-1:0] mem_raddr,
	input  logic [SW-1:0] mem_rdata,
	input  logic          res_free,
	output logic          res_load,
	output result_t       res_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DECIDE = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	localparam logic [LAYER_ID_W-1:0] NUM_ID    = LAYER_ID_W'(NUM_LAYERS);
	localparam logic [LAYER_ID_W-1:0] LAYER_ERR = LAYER_ID_W'(NUM_LAYERS - 1);
	localparam logic [LW-1:0]         LAST_IDX  = LW'(NUM_LAYERS - 1);
	localparam bit                    FG_EXISTS = (NUM_LAYERS > 4);

	state_t                 state_q;
	logic [NUM_LAYERS-1:0]  active_q;
	logic                   on_q;
	logic [LW-1:0]          shown_layer_q;
	logic [CUE_WIDTH-1:0]   shown_cue_q;

	logic [LW-1:0]          chk_q;
	logic                   found_q;
	logic [LW-1:0]          sel_idx_q;
	logic [CUE_WIDTH-1:0]   sel_cue_q;
	logic [INTENSITY_W-1:0] sel_int_q;
	logic [TIME_W-1:0]      now_q;
	logic                   status_q;
	cmd_t                   plan_q [3];
	logic [1:0]             cnt_q;
	logic [1:0]             emit_q;

	req_type_t              rtype;
	logic                   req_fire;
	logic [LAYER_ID_W-1:0]  layer_id;
	logic                   layer_ok;
	logic [CUE_WIDTH-1:0]   cue_w;
	logic [CUE_WIDTH-1:0]   err_w;
	logic                   fill_ok;
	logic [LAYER_ID_W-1:0]  play_id;
	logic                   play_ok;
	logic [TIME_W:0]        exp_sum;
	logic [TIME_W-1:0]      fill_exp;

	logic [CUE_WIDTH-1:0]   rd_cue;
	logic [INTENSITY_W-1:0] rd_int;
	logic [TIME_W-1:0]      rd_exp;
	logic                   expired;
	logic                   keep;
	logic                   changed;
	logic                   emit_last;
	cmd_t                   cur_cmd;
	logic [LAYER_ID_W-1:0]  shown_id;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rtype     = req_type_t'(req.req_type);

	assign layer_id = LAYER_ID_W'(req.layer);
	assign layer_ok = (layer_id < NUM_ID);
	assign cue_w    = CUE_WIDTH'(req.cue);
	assign err_w    = CUE_WIDTH'(cfg.error_cue);
	assign fill_ok  = layer_ok && (req.intensity <= cfg.max_intensity);
	assign play_id  = (cue_w == err_w) ? LAYER_ERR : LAYER_FOREGROUND;
	assign play_ok  = (play_id < NUM_ID) && (cfg.fg_intensity <= cfg.max_intensity);

	// saturating expiry, zero duration never runs out
	assign exp_sum  = {1'b0, req.now_time} + {1'b0, req.duration};
	always_comb begin
		if (req.duration == '0) begin
			fill_exp = '0;
		end else if (exp_sum[TIME_W]) begin
			fill_exp = TIME_MAX;
		end else begin
			fill_exp = exp_sum[TIME_W-1:0];
		end
	end

	always_comb begin
		mem_we    = req_fire && (((rtype == REQ_FILL) && fill_ok) ||
			((rtype == REQ_PLAY) && play_ok));
		mem_waddr = (rtype == REQ_PLAY) ? play_id[LW-1:0] : layer_id[LW-1:0];
		if (rtype == REQ_PLAY) begin
			mem_wdata = {cue_w, cfg.fg_intensity, {TIME_W{1'b0}}};
		end else begin
			mem_wdata = {cue_w, req.intensity, fill_exp};
		end
	end

	// scan reads one slot ahead of the one being checked
	assign mem_raddr = ((state_q == ST_SCAN) && (chk_q != LAST_IDX)) ? chk_q + 1'b1 : '0;

	assign rd_cue  = mem_rdata[SW-1 -: CUE_WIDTH];
	assign rd_int  = mem_rdata[TIME_W +: INTENSITY_W];
	assign rd_exp  = mem_rdata[TIME_W-1:0];
	assign expired = active_q[chk_q] && (rd_exp != '0) && (now_q >= rd_exp);
	assign keep    = active_q[chk_q] && !expired;
	assign changed = !on_q || (sel_idx_q != shown_layer_q) || (sel_cue_q != shown_cue_q);

	assign emit_last = (emit_q == cnt_q - 2'd1);
	assign cur_cmd   = plan_q[emit_q];
	assign shown_id  = LAYER_ID_W'(shown_layer_q);
	assign res_load  = (state_q == ST_EMIT) && res_free;

	always_comb begin
		res_data               = '0;
		res_data.command       = cur_cmd;
		res_data.cmd_cue       = (cur_cmd == CMD_PLAY) ? PORT_CUE_W'(sel_cue_q) : '0;
		res_data.cmd_intensity = (cur_cmd == CMD_SET) ? sel_int_q : '0;
		res_data.cmd_time      = (cur_cmd == CMD_TICK) ? now_q : '0;
		res_data.status        = status_q;
		res_data.last          = emit_last;
		res_data.emitting      = on_q;
		res_data.shown_cue     = PORT_CUE_W'(shown_cue_q);
		res_data.interferes    = on_q && ((shown_id == LAYER_TOUCH) ||
			(shown_id == LAYER_FOREGROUND) || (shown_id == LAYER_GROWTH) ||
			(shown_id == LAYER_ERR));
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_q      <= '0;
			on_q          <= 1'b0;
			shown_layer_q <= '0;
			shown_cue_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						unique case (rtype)
							REQ_TICK: begin
								state_q <= ST_SCAN;
							end
							REQ_FILL: begin
								if (fill_ok) begin
									active_q[layer_id[LW-1:0]] <= 1'b1;
								end
								state_q <= ST_EMIT;
							end
							REQ_CLEAR: begin
								if (layer_ok) begin
									active_q[layer_id[LW-1:0]] <= 1'b0;
								end
								state_q <= ST_EMIT;
							end
							REQ_PLAY: begin
								if (play_ok) begin
									active_q[play_id[LW-1:0]] <= 1'b1;
								end
								state_q <= ST_EMIT;
							end
							REQ_STOP: begin
								if (FG_EXISTS) begin
									active_q[LAYER_FOREGROUND[LW-1:0]] <= 1'b0;
								end
								active_q[LAYER_ERR[LW-1:0]] <= 1'b0;
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (expired) begin
						active_q[chk_q] <= 1'b0;
					end
					if (chk_q == LAST_IDX) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!found_q) begin
						on_q <= 1'b0;
					end else if (changed) begin
						on_q          <= 1'b1;
						shown_layer_q <= sel_idx_q;
						shown_cue_q   <= sel_cue_q;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_free && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and command plan
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					now_q     <= req.now_time;
					chk_q     <= '0;
					found_q   <= 1'b0;
					emit_q    <= '0;
					cnt_q     <= 2'd1;
					plan_q[0] <= CMD_ACK;
					unique case (rtype)
						REQ_TICK:  status_q <= 1'b0;
						REQ_FILL:  status_q <= !fill_ok;
						REQ_CLEAR: status_q <= 1'b0;
						REQ_PLAY:  status_q <= !play_ok;
						REQ_STOP:  status_q <= 1'b0;
						default:   status_q <= 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				if (keep) begin
					found_q   <= 1'b1;
					sel_idx_q <= chk_q;
					sel_cue_q <= rd_cue;
					sel_int_q <= rd_int;
				end
				if (chk_q != LAST_IDX) begin
					chk_q <= chk_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				emit_q <= '0;
				if (!found_q) begin
					plan_q[0] <= on_q ? CMD_STOP : CMD_ACK;
					cnt_q     <= 2'd1;
				end else if (changed) begin
					plan_q[0] <= CMD_SET;
					plan_q[1] <= CMD_PLAY;
					plan_q[2] <= CMD_TICK;
					cnt_q     <= 2'd3;
				end else begin
					plan_q[0] <= CMD_SET;
					plan_q[1] <= CMD_TICK;
					cnt_q     <= 2'd2;
				end
			end
			ST_EMIT: begin
				if (res_free && !emit_last) begin
					emit_q <= emit_q + 2'd1;
				end
			end
			default: begin
				emit_q <= '0;
			end
		endcase
	end

endmodule

### hdl/layered_light_priority_arbiter.sv
// layered light arbiter: one slot per light layer, higher layer number wins
//
// req channel: one request per event (tick, fill, clear, play, stop), taken
//   whenever the sequencer is idle, even while a result still sits in the
//   output register
// res channel: one to three results per request, the final one flagged by
//   last; results leave in order through a single output register
// cfg channel: register writes, always ready, applied at the handshake edge
//   index 0 max intensity, 1 play intensity (clamped), 2 error cue code
//
// sequence: fill, clear, play and stop go straight to the emit step, and their
//   result is then registered in the output register; a tick walks the slot
//   memory one entry per cycle, then decides, and its results follow one per
//   cycle while the output register is free; the next request is taken once
//   the last result has moved into the output register
// stall: a held res.ready freezes the output register and the emit step,
//   no result is dropped or repeated
// reset: all slots inactive, light off, registers at their reset values;
//   slot memory contents are only used for slots that a fill or play has written
module layered_light_priority_arbiter import llpa_pkg::*; #(
	parameter int NUM_LAYERS = 7,
	parameter int CUE_WIDTH = 8
) (
	input logic        clk,
	input logic        arst_n,
	llpa_req_if.sink   req,
	llpa_res_if.source res,
	llpa_cfg_if.sink   cfg
);

	localparam int LW = $clog2(NUM_LAYERS);
	localparam int SW = CUE_WIDTH + INTENSITY_W + TIME_W;

	// configuration registers
	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_intensity <= '1;
			cfg_q.fg_intensity  <= '0;
			cfg_q.error_cue     <= '1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_MAX_INTENSITY: cfg_q.max_intensity <= cfg.data;
				// play intensity is clamped to the current ceiling
				CFG_FG_INTENSITY: cfg_q.fg_intensity <= (cfg.data < cfg_q.max_intensity) ?
					cfg.data : cfg_q.max_intensity;
				CFG_ERROR_CUE: cfg_q.error_cue <= cfg.data[PORT_CUE_W-1:0];
				default: ;
			endcase
		end
	end

	// slot memory: cue, intensity, expiry per layer
	logic          mem_we;
	logic [LW-1:0] mem_waddr;
	logic [SW-1:0] mem_wdata;
	logic [LW-1:0] mem_raddr;
	logic [SW-1:0] mem_rdata;

	llpa_slot_mem #(
		.DEPTH(NUM_LAYERS),
		.WIDTH(SW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// sequencer: applies requests, scans slots on tick, plans the commands
	logic    res_free;
	logic    res_load;
	result_t res_data;

	llpa_ctrl #(
		.NUM_LAYERS(NUM_LAYERS),
		.CUE_WIDTH (CUE_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg_q),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_free (res_free),
		.res_load (res_load),
		.res_data (res_data)
	);

	// output register, free when empty or being drained this cycle
	logic    res_valid_q;
	result_t res_q;

	assign res_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_data;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.command       = res_q.command;
	assign res.cmd_cue       = res_q.cmd_cue;
	assign res.cmd_intensity = res_q.cmd_intensity;
	assign res.cmd_time      = res_q.cmd_time;
	assign res.status        = res_q.status;
	assign res.last          = res_q.last;
	assign res.emitting      = res_q.emitting;
	assign res.shown_cue     = res_q.shown_cue;
	assign res.interferes    = res_q.interferes;

endmodule
